>>> hw/rtl/snaf_pkg.sv
// Shared constants for the signed number to ASCII field unit.
package snaf_pkg;

  localparam int MagW = 17;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  localparam logic signed [31:0] INT_HI  = 32'sd99999;
  localparam logic signed [31:0] INT_LO  = -32'sd9999;
  localparam logic signed [31:0] TEN_HI  = 32'sd9999;
  localparam logic signed [31:0] TEN_LO  = -32'sd999;

  localparam logic [MagW-1:0] INT_HI_MAG = 17'd99999;
  localparam logic [MagW-1:0] INT_LO_MAG = 17'd9999;
  localparam logic [MagW-1:0] TEN_HI_MAG = 17'd9999;
  localparam logic [MagW-1:0] TEN_LO_MAG = 17'd999;

  localparam logic [19:0] RECIP_10    = 20'd838861;
  localparam logic [19:0] RECIP_100   = 20'd167773;
  localparam logic [19:0] RECIP_1000  = 20'd134218;
  localparam logic [19:0] RECIP_10000 = 20'd107375;

  localparam logic KIND_INT    = 1'b0;
  localparam logic KIND_TENTHS = 1'b1;

  typedef logic [7:0] char_t;

endpackage

>>> hw/rtl/signed_number_to_ascii_field_unit.sv
// Signed number to five-character ASCII display field, three-register pipeline.
//
// Input channel in_*: one transaction carries a signed 32-bit value in in_tdata and the
// mode in in_tuser (0 plain integer, 1 value in tenths with one decimal).
// Output channel out_*: one transaction per input carries five ASCII characters,
// ch0 (leftmost) in the lowest byte of out_tdata.
// Out-of-range values saturate to the mode's limit without any flag.
// An accepted item passes the input, quotient and result registers in turn.
// Throughput: one item per cycle while out_tready is high; the pipeline is set by an
// input register, a register after the constant-reciprocal multipliers that give the
// decimal quotients, and the result register that picks digits, spaces, sign and point.
// Reset: synchronous, active low; clears all valid flags, the pipeline is empty
// and in_tready is high after reset.
// Stall: when out_tready is low the result holds; earlier stages keep advancing
// into empty slots, so up to two further items are accepted before in_tready
// drops.
module signed_number_to_ascii_field_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic        in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // ch0[7:0], ch1[15:8], ch2[23:16], ch3[31:24], ch4[39:32]
);
  import snaf_pkg::*;

  logic                     s1_valid_r;
  logic                     s1_kind_r;
  logic signed [31:0]       s1_value_r;

  logic                     s2_valid_r;
  logic                     s2_kind_r;
  logic                     s2_neg_r;
  logic [3:0]               s2_mlo_r;
  logic [13:0]              s2_q1_r;
  logic [9:0]               s2_q2_r;
  logic [6:0]               s2_q3_r;
  logic [3:0]               s2_q4_r;

  logic                     out_valid_r;
  logic [39:0]              out_data_r;

  logic                     out_adv;
  logic                     s2_adv;
  logic                     s1_adv;

  logic                     neg_nxt;
  logic [MagW-1:0]          mag_nxt;
  logic [31:0]              negv;
  logic [36:0]              prod1, prod2, prod3, prod4;

  logic [3:0]               d0, d1, d2, d3, d4;
  char_t                    c0, c1, c2, c3, c4;
  logic [39:0]              out_data_nxt;

  function automatic logic [3:0] times10_lo(input logic [3:0] x);
    times10_lo = 4'({x[0], 3'b000}) + 4'({x[2:0], 1'b0});
  endfunction

  function automatic char_t dchar(input logic [3:0] d);
    dchar = CH_ZERO | {4'b0000, d};
  endfunction

  assign out_adv   = !out_valid_r || out_tready;
  assign s2_adv    = !s2_valid_r || out_adv;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign in_tready = s1_adv;

  // saturate, take magnitude, and form decimal quotients
  always_comb begin
    negv = -s1_value_r;
    if (s1_kind_r == KIND_TENTHS) begin
      if (s1_value_r > TEN_HI) begin
        neg_nxt = 1'b0;
        mag_nxt = TEN_HI_MAG;
      end else if (s1_value_r < TEN_LO) begin
        neg_nxt = 1'b1;
        mag_nxt = TEN_LO_MAG;
      end else begin
        neg_nxt = s1_value_r[31];
        mag_nxt = s1_value_r[31] ? negv[MagW-1:0] : s1_value_r[MagW-1:0];
      end
    end else begin
      if (s1_value_r > INT_HI) begin
        neg_nxt = 1'b0;
        mag_nxt = INT_HI_MAG;
      end else if (s1_value_r < INT_LO) begin
        neg_nxt = 1'b1;
        mag_nxt = INT_LO_MAG;
      end else begin
        neg_nxt = s1_value_r[31];
        mag_nxt = s1_value_r[31] ? negv[MagW-1:0] : s1_value_r[MagW-1:0];
      end
    end
    prod1 = 37'(mag_nxt) * 37'(RECIP_10);
    prod2 = 37'(mag_nxt) * 37'(RECIP_100);
    prod3 = 37'(mag_nxt) * 37'(RECIP_1000);
    prod4 = 37'(mag_nxt) * 37'(RECIP_10000);
  end

  // pick digits and lay out the field
  always_comb begin
    d0 = s2_mlo_r - times10_lo(s2_q1_r[3:0]);
    d1 = s2_q1_r[3:0] - times10_lo(s2_q2_r[3:0]);
    d2 = s2_q2_r[3:0] - times10_lo(s2_q3_r[3:0]);
    d3 = s2_q3_r[3:0] - times10_lo(s2_q4_r);
    d4 = s2_q4_r;
    c0 = CH_SPACE;
    c1 = CH_SPACE;
    c2 = CH_SPACE;
    c3 = CH_SPACE;
    c4 = CH_SPACE;
    if (s2_kind_r == KIND_TENTHS) begin
      if (!s2_neg_r) begin
        if (s2_q3_r != '0) begin
          c0 = dchar(d3); c1 = dchar(d2); c2 = dchar(d1); c3 = CH_POINT; c4 = dchar(d0);
        end else if (s2_q2_r != '0) begin
          c1 = dchar(d2); c2 = dchar(d1); c3 = CH_POINT; c4 = dchar(d0);
        end else begin
          c1 = dchar(d1); c2 = CH_POINT; c3 = dchar(d0);
        end
      end else begin
        if (s2_q2_r != '0) begin
          c0 = CH_MINUS; c1 = dchar(d2); c2 = dchar(d1); c3 = CH_POINT; c4 = dchar(d0);
        end else begin
          c1 = CH_MINUS; c2 = dchar(d1); c3 = CH_POINT; c4 = dchar(d0);
        end
      end
    end else begin
      if (!s2_neg_r) begin
        if (s2_q4_r != '0) begin
          c0 = dchar(d4); c1 = dchar(d3); c2 = dchar(d2); c3 = dchar(d1); c4 = dchar(d0);
        end else if (s2_q3_r != '0) begin
          c1 = dchar(d3); c2 = dchar(d2); c3 = dchar(d1); c4 = dchar(d0);
        end else if (s2_q2_r != '0) begin
          c1 = dchar(d2); c2 = dchar(d1); c3 = dchar(d0);
        end else if (s2_q1_r != '0) begin
          c2 = dchar(d1); c3 = dchar(d0);
        end else begin
          c3 = dchar(d0);
        end
      end else begin
        if (s2_q3_r != '0) begin
          c0 = CH_MINUS; c1 = dchar(d3); c2 = dchar(d2); c3 = dchar(d1); c4 = dchar(d0);
        end else if (s2_q2_r != '0) begin
          c1 = CH_MINUS; c2 = dchar(d2); c3 = dchar(d1); c4 = dchar(d0);
        end else if (s2_q1_r != '0) begin
          c1 = CH_MINUS; c2 = dchar(d1); c3 = dchar(d0);
        end else begin
          c2 = CH_MINUS; c3 = dchar(d0);
        end
      end
    end
    out_data_nxt = {c4, c3, c2, c1, c0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      s1_kind_r  <= in_tuser;
      s1_value_r <= in_tdata;
    end
    if (s2_adv && s1_valid_r) begin
      s2_kind_r <= s1_kind_r;
      s2_neg_r  <= neg_nxt;
      s2_mlo_r  <= mag_nxt[3:0];
      s2_q1_r   <= prod1[36:23];
      s2_q2_r   <= prod2[33:24];
      s2_q3_r   <= prod3[33:27];
      s2_q4_r   <= prod4[33:30];
    end
    if (out_adv && s2_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> tb/sv/tb_signed_number_to_ascii_field_unit.sv
// Testbench: random and directed number formatting through the ASCII field unit, checked per field.
module tb_signed_number_to_ascii_field_unit;
  import snaf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int GAP_PCT     = 16;
  localparam int MAX_REPORTS = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = KIND_INT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  logic [39:0] pending_fields [$];
  bit          gaps_on = 1'b1;
  int          mismatches;
  int          int_items;
  int          tenths_items;
  int          clipped_items;
  int          fields_checked;
  int          quiet_cycles;

  signed_number_to_ascii_field_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic is_clipped(logic kind, logic [31:0] raw);
    int v;
    v = raw;
    if (kind == KIND_TENTHS) begin
      return (v > TEN_HI) || (v < TEN_LO);
    end
    return (v > INT_HI) || (v < INT_LO);
  endfunction

  function automatic logic [39:0] format_field(logic kind, logic [31:0] raw);
    int    v;
    int    m;
    int    ndig;
    int    p;
    int    pos;
    int    lastp;
    int    i;
    logic  neg;
    logic  tenths;
    char_t c [5];
    tenths = (kind == KIND_TENTHS);
    v = raw;
    if (tenths) begin
      if (v > TEN_HI) v = TEN_HI;
      else if (v < TEN_LO) v = TEN_LO;
    end else begin
      if (v > INT_HI) v = INT_HI;
      else if (v < INT_LO) v = INT_LO;
    end
    neg = (v < 0);
    m = neg ? -v : v;
    ndig = 1;
    p = 10;
    while (ndig < 5 && m >= p) begin
      ndig++;
      p *= 10;
    end
    if (tenths && ndig < 2) ndig = 2;
    if (tenths) lastp = (neg || m >= 100) ? 4 : 3;
    else lastp = (m >= (neg ? 100 : 1000)) ? 4 : 3;
    for (i = 0; i < 5; i++) c[i] = CH_SPACE;
    pos = lastp;
    p = 1;
    for (i = 0; i < ndig; i++) begin
      if (tenths && i == 1) begin
        c[pos] = CH_POINT;
        pos--;
      end
      c[pos] = CH_ZERO + char_t'((m / p) % 10);
      pos--;
      p *= 10;
    end
    if (neg) c[pos] = CH_MINUS;
    return {c[4], c[3], c[2], c[1], c[0]};
  endfunction

  function automatic logic [31:0] pick_value(logic kind);
    int sel;
    int v;
    int span;
    sel = $urandom_range(9);
    span = (kind == KIND_TENTHS) ? 10000 : 100000;
    case (sel)
      0, 1, 2: begin
        v = $urandom_range(span - 1);
        if ($urandom_range(1)) v = -v;
      end
      3, 4: begin
        v = $urandom_range(120);
        if ($urandom_range(1)) v = -v;
      end
      5, 6: begin
        case ($urandom_range(5))
          0: v = 1;
          1: v = 10;
          2: v = 100;
          3: v = 1000;
          4: v = 10000;
          default: v = 100000;
        endcase
        v = v + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = -v;
      end
      7, 8: v = $urandom;
      default: begin
        if ($urandom_range(1)) v = 32'h7fff_ffff - $urandom_range(3);
        else v = 32'h8000_0000 + $urandom_range(3);
      end
    endcase
    return v;
  endfunction

  task automatic send_item(input logic kind, input logic [31:0] value);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_fields.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic test_integer_layout();
    int vals [13];
    int i;
    vals = '{0, 7, -5, -99, 999, -100, 1000, -9999, 99999, 100000, -10000,
             32'h7fff_ffff, 32'h8000_0000};
    for (i = 0; i < 13; i++) send_item(KIND_INT, vals[i]);
  endtask

  task automatic test_tenths_layout();
    int vals [12];
    int i;
    vals = '{0, 5, 99, -1, -99, 100, 9999, -100, -999, 10000, -1000, 32'h7fff_ffff};
    for (i = 0; i < 12; i++) send_item(KIND_TENTHS, vals[i]);
  endtask

  task automatic test_random_mixed(input int count);
    int   i;
    logic kind;
    gaps_on = 1'b1;
    for (i = 0; i < count; i++) begin
      kind = 1'($urandom_range(1));
      send_item(kind, pick_value(kind));
    end
  endtask

  task automatic test_back_to_back(input int count);
    int   i;
    logic kind;
    gaps_on = 1'b0;
    for (i = 0; i < count; i++) begin
      kind = 1'($urandom_range(1));
      send_item(kind, pick_value(kind));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_full_range(input int count);
    int i;
    gaps_on = 1'b1;
    for (i = 0; i < count; i++) send_item(1'($urandom_range(1)), $urandom);
  endtask

  task automatic note_failure(input string what, input logic [39:0] want,
                              input logic [39:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_fields.push_back(format_field(in_tuser, in_tdata));
      if (in_tuser == KIND_TENTHS) tenths_items++;
      else int_items++;
      if (is_clipped(in_tuser, in_tdata)) clipped_items++;
    end
  end

  always @(posedge clk) begin
    logic [39:0] want;
    int          k;
    int          bad_ch;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fields.size() == 0) begin
        note_failure("result with nothing pending", 'x, out_tdata);
      end else begin
        want = pending_fields.pop_front();
        fields_checked++;
        bad_ch = -1;
        for (k = 4; k >= 0; k--) begin
          if (want[8*k +: 8] !== out_tdata[8*k +: 8]) bad_ch = k;
        end
        if (bad_ch >= 0) note_failure($sformatf("mismatch from ch%0d", bad_ch), want, out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", quiet_cycles);
      $display("tb_signed_number_to_ascii_field_unit failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_integer_layout();
    test_tenths_layout();
    wait_drained();
    test_random_mixed(900);
    wait_drained();
    test_back_to_back(300);
    wait_drained();
    test_full_range(350);
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Formatted %0d integer and %0d tenths values (%0d clipped), %0d fields checked,",
             int_items, tenths_items, clipped_items, fields_checked);
    $display("with random gaps on both sides and a back-to-back stretch; mismatches: %0d",
             mismatches);
    if (mismatches == 0 && pending_fields.size() == 0) begin
      $display("tb_signed_number_to_ascii_field_unit passed");
    end else begin
      $display("tb_signed_number_to_ascii_field_unit failed");
    end
    $finish;
  end

endmodule

>>> signed_number_to_ascii_field_unit.f
hw/rtl/snaf_pkg.sv
hw/rtl/signed_number_to_ascii_field_unit.sv
tb/sv/tb_signed_number_to_ascii_field_unit.sv
